### rtl/core/tmfd_pkg.sv
`default_nettype none

package tmfd_pkg;

  // Buffer geometry: one bank of message bytes per queue slot
  localparam int unsigned BufBytes = 64;
  localparam int unsigned BufAw    = $clog2(BufBytes);
  localparam int unsigned QDepth   = 2;
  localparam int unsigned RamDepth = QDepth * BufBytes;
  localparam int unsigned RamAw    = $clog2(RamDepth);

  // Time conversion in 64 us steps: seconds = quad / 15625 by reciprocal
  // multiply, nanoseconds = remainder * 64000
  localparam logic [13:0] QuadPerSec = 14'd15625;
  localparam logic [26:0] SecRecip   = 27'd70368745;  // ceil(2^40 / 15625)
  localparam int unsigned SecShift   = 40;
  localparam logic [15:0] NsPerQuad  = 16'd64000;
  localparam int unsigned SecsBits   = 13;
  localparam logic [13:0] BendCenter = 14'h2000;

  // Expected frame lengths
  localparam logic [7:0] MsgLenThree = 8'd3;
  localparam logic [7:0] MsgLenTwo   = 8'd2;

  // Status high nibbles
  localparam logic [3:0] StNoteOff   = 4'h8;
  localparam logic [3:0] StNoteOn    = 4'h9;
  localparam logic [3:0] StKeyPress  = 4'hA;
  localparam logic [3:0] StCtrl      = 4'hB;
  localparam logic [3:0] StProgram   = 4'hC;
  localparam logic [3:0] StChanPress = 4'hD;
  localparam logic [3:0] StPitchBend = 4'hE;
  localparam logic [3:0] StSysex     = 4'hF;

  typedef enum logic [3:0] {
    KindNoteOff   = 4'd0,
    KindNoteOn    = 4'd1,
    KindKeyPress  = 4'd2,
    KindCtrl      = 4'd3,
    KindProgram   = 4'd4,
    KindChanPress = 4'd5,
    KindPitchBend = 4'd6,
    KindSysex     = 4'd7,
    KindInvalid   = 4'd8
  } kind_e;

  // One completed frame as handed from front to back
  typedef struct packed {
    logic [7:0]  frame_len;
    logic [23:0] evt_time;
    logic [7:0]  status;
    logic [6:0]  b1;
    logic [6:0]  b2;
  } frame_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
    logic wr_bank;
    logic rd_bank;
  } q_status_t;

  // Decoded message fields
  typedef struct packed {
    kind_e              kind;
    logic [6:0]         key;
    logic signed [13:0] value;
    logic               lerr;
    logic               sysex;
    logic [BufAw-1:0]   cnt;
  } dec_t;

  function automatic dec_t decode(frame_t f);
    dec_t       d;
    logic [3:0] hi;
    logic [8:0] cnt;
    d   = '0;
    hi  = f.status[7:4];
    cnt = {1'b0, f.frame_len} - 9'd1;
    d.kind = KindInvalid;
    unique case (hi) inside
      StNoteOff, StNoteOn, StKeyPress, StCtrl: begin
        // kind code follows the status nibble order
        d.kind  = kind_e'(hi - StNoteOff);
        d.key   = f.b1;
        d.value = {7'd0, f.b2};
        d.lerr  = (f.frame_len != MsgLenThree);
      end
      StProgram, StChanPress: begin
        d.kind  = kind_e'(hi - StNoteOff);
        d.value = {7'd0, f.b1};
        d.lerr  = (f.frame_len != MsgLenTwo);
      end
      StPitchBend: begin
        d.kind  = KindPitchBend;
        d.value = {f.b2, f.b1} - BendCenter;
        d.lerr  = (f.frame_len != MsgLenThree);
      end
      StSysex: begin
        d.kind  = KindSysex;
        d.sysex = 1'b1;
        d.lerr  = ({1'b0, f.frame_len} > 9'(BufBytes));
        if (cnt > 9'(BufBytes - 1)) begin
          cnt = 9'(BufBytes - 1);
        end
        d.cnt = cnt[BufAw-1:0];
      end
      default: begin
        d.kind = KindInvalid;
      end
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

### rtl/core/tmfd_ram.sv
`default_nettype none

module tmfd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128,
  localparam int unsigned Aw = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/core/tmfd_front.sv
`default_nettype none

module tmfd_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [7:0]               stream_byte_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire tmfd_pkg::q_status_t      q_stat_i,
  output logic                          push_o,
  output tmfd_pkg::frame_t              push_frame_o,
  output logic                          ram_we_o,
  output logic [tmfd_pkg::RamAw-1:0]    ram_waddr_o,
  output logic [7:0]                    ram_wdata_o
);
  import tmfd_pkg::*;

  typedef enum logic [2:0] {
    PhLen,
    PhTime0,
    PhTime1,
    PhTime2,
    PhData
  } phase_e;

  phase_e      phase_q;
  logic [7:0]  len_q;
  logic [23:0] time_q;
  logic [7:0]  idx_q;
  logic [7:0]  status_q;
  logic [6:0]  b1_q;
  logic [6:0]  b2_q;

  logic       accept;
  logic [7:0] idx_next;
  logic       at_end;
  logic [7:0] status_w;
  logic [6:0] b1_w;
  logic [6:0] b2_w;

  // Hold message bytes back only when no bank is free for them
  assign in_ready_o = !((phase_q == PhData) && q_stat_i.full);
  assign accept     = in_valid_i && in_ready_o;
  assign idx_next   = idx_q + 8'd1;
  assign at_end     = (phase_q == PhData) && (idx_next == len_q);

  // Fold the current byte into the header fields
  always_comb begin
    status_w = (idx_q == 8'd0) ? stream_byte_i : status_q;
    b1_w     = (idx_q == 8'd1) ? stream_byte_i[6:0] : b1_q;
    b2_w     = (idx_q == 8'd2) ? stream_byte_i[6:0] : b2_q;
  end

  assign push_o       = accept && at_end;
  assign push_frame_o = '{frame_len: len_q, evt_time: time_q, status: status_w,
                          b1: b1_w, b2: b2_w};

  // Store message bytes that fit the bank; drop the rest
  assign ram_we_o    = accept && (phase_q == PhData) &&
                       ({1'b0, idx_q} < 9'(BufBytes));
  assign ram_waddr_o = {q_stat_i.wr_bank, idx_q[BufAw-1:0]};
  assign ram_wdata_o = stream_byte_i;

  // Walk the frame prefix and the message bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhLen;
      len_q    <= '0;
      time_q   <= '0;
      idx_q    <= '0;
      status_q <= '0;
      b1_q     <= '0;
      b2_q     <= '0;
    end else if (accept) begin
      unique case (phase_q)
        PhLen: begin
          len_q   <= stream_byte_i;
          phase_q <= PhTime0;
        end
        PhTime0: begin
          time_q  <= {time_q[15:0], stream_byte_i};
          phase_q <= PhTime1;
        end
        PhTime1: begin
          time_q  <= {time_q[15:0], stream_byte_i};
          phase_q <= PhTime2;
        end
        PhTime2: begin
          time_q   <= {time_q[15:0], stream_byte_i};
          idx_q    <= '0;
          status_q <= '0;
          b1_q     <= '0;
          b2_q     <= '0;
          phase_q  <= (len_q == 8'd0) ? PhLen : PhData;
        end
        PhData: begin
          status_q <= status_w;
          b1_q     <= b1_w;
          b2_q     <= b2_w;
          if (at_end) begin
            idx_q   <= '0;
            phase_q <= PhLen;
          end else begin
            idx_q <= idx_next;
          end
        end
        default: begin
          phase_q <= PhLen;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/tmfd_queue.sv
`default_nettype none

module tmfd_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire tmfd_pkg::frame_t    push_frame_i,
  input  wire logic                pop_i,
  output tmfd_pkg::frame_t         head_o,
  output tmfd_pkg::q_status_t      stat_o
);
  import tmfd_pkg::*;

  localparam int unsigned CntW = $clog2(QDepth + 1);

  frame_t          slot_q [QDepth];
  logic            wr_ptr_q;
  logic            rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign head_o         = slot_q[rd_ptr_q];
  assign stat_o.full    = (cnt_q == CntW'(QDepth));
  assign stat_o.empty   = (cnt_q == '0);
  assign stat_o.wr_bank = wr_ptr_q;
  assign stat_o.rd_bank = rd_ptr_q;

  // Store a pushed frame
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_frame_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/tmfd_back.sv
`default_nettype none

module tmfd_back (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire tmfd_pkg::frame_t         head_i,
  input  wire tmfd_pkg::q_status_t      q_stat_i,
  output logic                          pop_o,
  output logic [tmfd_pkg::RamAw-1:0]    ram_raddr_o,
  input  wire logic [7:0]               ram_rdata_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [3:0]                    event_kind_o,
  output logic [3:0]                    channel_o,
  output logic [6:0]                    key_or_param_o,
  output logic signed [13:0]            event_value_o,
  output logic [7:0]                    sysex_byte_o,
  output logic                          sysex_byte_valid_o,
  output logic                          length_error_o,
  output logic [12:0]                   time_seconds_o,
  output logic [29:0]                   time_nanoseconds_o,
  output logic                          last_o
);
  import tmfd_pkg::*;

  typedef enum logic [2:0] {
    BkIdle,
    BkRem,
    BkScale,
    BkRead,
    BkPut
  } back_state_e;

  back_state_e        state_q;
  logic [13:0]        rem_q;
  logic [12:0]        secs_q;
  logic [29:0]        ns_q;
  logic [BufAw-1:0]   idx_q;
  logic               out_valid_q;
  kind_e              kind_q;
  logic [3:0]         chan_q;
  logic [6:0]         key_q;
  logic signed [13:0] value_q;
  logic [7:0]         sx_q;
  logic               sxv_q;
  logic               lerr_q;
  logic               last_q;

  dec_t        dec;
  logic [25:0] quad;
  logic [52:0] quot_prod;
  logic [26:0] sec_quads;
  logic [26:0] rem_full;
  logic        out_free;
  logic        sx_run;
  logic        put_last;

  // Classify the head frame
  assign dec = decode(head_i);

  // Scheduled time in 64 us steps; seconds by reciprocal multiply
  assign quad      = {head_i.evt_time, 2'b00};
  assign quot_prod = {27'd0, quad} * {26'd0, SecRecip};
  assign sec_quads = {14'd0, secs_q} * {13'd0, QuadPerSec};
  assign rem_full  = {1'b0, quad} - sec_quads;

  assign out_free    = !out_valid_q || out_ready_i;
  assign sx_run      = dec.sysex && (dec.cnt != '0);
  assign put_last    = !sx_run || (idx_q == dec.cnt);
  assign pop_o       = (state_q == BkPut) && out_free && put_last;
  assign ram_raddr_o = {q_stat_i.rd_bank, idx_q};

  // Sequence time conversion and result emission
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      rem_q       <= '0;
      secs_q      <= '0;
      ns_q        <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= KindInvalid;
      chan_q      <= '0;
      key_q       <= '0;
      value_q     <= '0;
      sx_q        <= '0;
      sxv_q       <= 1'b0;
      lerr_q      <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        BkIdle: begin
          // hold the time fields until the waiting item leaves
          if (!q_stat_i.empty && out_free) begin
            secs_q  <= quot_prod[SecShift +: SecsBits];
            state_q <= BkRem;
          end
        end
        BkRem: begin
          rem_q   <= rem_full[13:0];
          state_q <= BkScale;
        end
        BkScale: begin
          ns_q    <= 30'(rem_q) * 30'(NsPerQuad);
          idx_q   <= BufAw'(1);
          state_q <= BkRead;
        end
        BkRead: begin
          state_q <= BkPut;
        end
        BkPut: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            kind_q      <= dec.kind;
            chan_q      <= head_i.status[3:0];
            key_q       <= dec.key;
            value_q     <= dec.value;
            sx_q        <= sx_run ? ram_rdata_i : 8'd0;
            sxv_q       <= sx_run;
            lerr_q      <= dec.lerr;
            last_q      <= put_last;
            if (put_last) begin
              state_q <= BkIdle;
            end else begin
              idx_q   <= idx_q + BufAw'(1);
              state_q <= BkRead;
            end
          end
        end
        default: begin
          state_q <= BkIdle;
        end
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign event_kind_o       = kind_q;
  assign channel_o          = chan_q;
  assign key_or_param_o     = key_q;
  assign event_value_o      = value_q;
  assign sysex_byte_o       = sx_q;
  assign sysex_byte_valid_o = sxv_q;
  assign length_error_o     = lerr_q;
  assign time_seconds_o     = secs_q;
  assign time_nanoseconds_o = ns_q;
  assign last_o             = last_q;

endmodule

`default_nettype wire

### rtl/core/timed_midi_frame_decoder_unit.sv
`default_nettype none

// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid_i/in_ready_o | stream_byte_i
// out     | output    | out_valid_o/out_ready_i | event_kind_o .. last_o
//
// Every stream byte is accepted while the front parser has room.
// A queued frame starts once the result register is free: the seconds by
// reciprocal multiply, then the remainder, a scaling step, then a read and a
// put state per result; sysex runs drain the message bank at that pace.
// Two frames may wait in the queue; a third frame stalls at its first
// message byte until the back end releases a bank. Reset is async, active low,
// and leaves the block waiting for a length byte with no clearing pass.
module timed_midi_frame_decoder_unit (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [7:0]    stream_byte_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [3:0]         event_kind_o,
  output logic [3:0]         channel_o,
  output logic [6:0]         key_or_param_o,
  output logic signed [13:0] event_value_o,
  output logic [7:0]         sysex_byte_o,
  output logic               sysex_byte_valid_o,
  output logic               length_error_o,
  output logic [12:0]        time_seconds_o,
  output logic [29:0]        time_nanoseconds_o,
  output logic               last_o
);
  import tmfd_pkg::*;

  q_status_t        q_stat;
  logic             push;
  frame_t           push_frame;
  logic             pop;
  frame_t           head;
  logic             ram_we;
  logic [RamAw-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic [RamAw-1:0] ram_raddr;
  logic [7:0]       ram_rdata;

  tmfd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stream_byte_i (stream_byte_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .push_frame_o  (push_frame),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata)
  );

  tmfd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_frame_i (push_frame),
    .pop_i        (pop),
    .head_o       (head),
    .stat_o       (q_stat)
  );

  tmfd_ram #(
    .Width (8),
    .Depth (RamDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tmfd_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .head_i             (head),
    .q_stat_i           (q_stat),
    .pop_o              (pop),
    .ram_raddr_o        (ram_raddr),
    .ram_rdata_i        (ram_rdata),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .event_kind_o       (event_kind_o),
    .channel_o          (channel_o),
    .key_or_param_o     (key_or_param_o),
    .event_value_o      (event_value_o),
    .sysex_byte_o       (sysex_byte_o),
    .sysex_byte_valid_o (sysex_byte_valid_o),
    .length_error_o     (length_error_o),
    .time_seconds_o     (time_seconds_o),
    .time_nanoseconds_o (time_nanoseconds_o),
    .last_o             (last_o)
  );

endmodule

`default_nettype wire
